### rtl/led_breath_color_cycler_assert.svh
// assertion helpers for the breath color cycler
`ifndef LED_BREATH_COLOR_CYCLER_ASSERT_SVH
`define LED_BREATH_COLOR_CYCLER_ASSERT_SVH

// ante true at a clock edge implies cons at the same edge
`define LBCC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante true at a clock edge implies cons at the next edge
`define LBCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lbcc_pkg.sv
package lbcc_pkg;

	localparam int PALETTE_SIZE = 3;

	localparam int PERIOD_MAX  = 5000;
	localparam int PERIOD_MIN  = 200;
	localparam int SPEED_MAX   = 100;
	localparam int SPEED_SLOPE = (PERIOD_MAX - PERIOD_MIN) / SPEED_MAX;
	localparam int STEP_SCALE  = 10000;
	localparam int PHASE_UNIT  = 1000;

	// dividend (max+1)*10000 needs 22 bits
	localparam int DIV_STEPS = 22;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [2:0] {
		REG_SPEED    = 3'd0,
		REG_MAXB     = 3'd1,
		REG_COUNT    = 3'd2,
		REG_PALETTE0 = 3'd3,
		REG_PALETTE1 = 3'd4,
		REG_PALETTE2 = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ACC,
		ST_LOOP,
		ST_FIN
	} state_t;

endpackage

### rtl/lbcc_if.sv
interface lbcc_tick_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink (input valid, input tick, output ready);
endinterface

interface lbcc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] level_now;
	logic [1:0] palette_index;
	logic       breath_done;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output level_now, output palette_index, output breath_done, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input level_now, input palette_index, input breath_done, output ready);
endinterface

interface lbcc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lbcc_pkg::CFG_IDX_W-1:0]   index;
	logic [lbcc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/led_breath_color_cycler.sv
// channel  | dir  | payload                                          | request
// ---------+------+--------------------------------------------------+---------------------
// ticks    | sink | tick                                             | one animation tick
// result   | src  | red/green/blue_out, level_now, palette_index,    | one per tick
//          |      | breath_done                                      |
// cfg      | sink | index (3b), data (24b)                           | register write
//
// A tick request is accepted, then the restoring divider forms the phase step
// (22 quotient bits), the step is added to the accumulator, and the accumulator
// gives up one whole 1000 per loop step (at most 13) until it is below 1000; then
// the result register is loaded. A zero tick goes straight to the result.
// ticks.ready is low while a request is at work.
// The last stage waits while the result register is still full and unread.
// Reset sets the registers to their defaults and clears all animation state.
`include "led_breath_color_cycler_assert.svh"

module led_breath_color_cycler (
	input  logic                 clk,
	input  logic                 arst_n,
	lbcc_tick_if.sink            ticks,
	lbcc_result_if.source        result,
	lbcc_cfg_if.sink             cfg
);

	// configuration
	logic [6:0]  speed_q;
	logic [7:0]  maxb_q;
	logic [1:0]  count_q;
	logic [23:0] palette_q [lbcc_pkg::PALETTE_SIZE];

	// animation state
	logic [13:0] phase_q;
	logic [8:0]  tri_q;
	logic [7:0]  level_q;
	logic [1:0]  slot_q;
	logic        done_q;

	// divider
	logic [12:0] period_q;
	logic [12:0] rem_q;
	logic [21:0] dvd_q;
	logic [4:0]  cnt_q;

	lbcc_pkg::state_t state_q, state_d;

	logic       out_valid_q;
	logic [7:0] red_q, green_q, blue_q;

	assign cfg.ready   = 1'b1;
	assign ticks.ready = (state_q == lbcc_pkg::ST_IDLE);

	logic accept;
	assign accept = ticks.valid && ticks.ready;

	// period = 5000 - speed*48, speed clamped at 100
	logic [6:0]  sp_c;
	logic [12:0] period_c;
	assign sp_c     = (speed_q > 7'(lbcc_pkg::SPEED_MAX)) ? 7'(lbcc_pkg::SPEED_MAX) : speed_q;
	assign period_c = 13'(lbcc_pkg::PERIOD_MAX)
		- 13'({6'd0, sp_c} * 13'(lbcc_pkg::SPEED_SLOPE));

	logic [8:0]  maxb_p1;
	logic [21:0] dividend_c;
	assign maxb_p1    = {1'b0, maxb_q} + 9'd1;
	assign dividend_c = 22'({13'd0, maxb_p1} * 22'(lbcc_pkg::STEP_SCALE));

	// one restoring divide step
	logic [13:0] trial;
	logic        trial_ge;
	assign trial    = {rem_q, dvd_q[21]};
	assign trial_ge = (trial >= {1'b0, period_q});

	// one accumulator step
	logic        phase_ge;
	logic [9:0]  tri_n;
	logic [9:0]  twice_max;
	logic [1:0]  count_eff;
	logic [1:0]  slot_n;
	assign phase_ge  = (phase_q >= 14'(lbcc_pkg::PHASE_UNIT));
	assign tri_n     = {1'b0, tri_q} + 10'd1;
	assign twice_max = {1'b0, maxb_q, 1'b0};
	assign slot_n    = slot_q + 2'd1;

	always_comb begin
		if (count_q == 2'd0) begin
			count_eff = 2'd1;
		end else if (count_q > 2'(lbcc_pkg::PALETTE_SIZE)) begin
			count_eff = 2'(lbcc_pkg::PALETTE_SIZE);
		end else begin
			count_eff = count_q;
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lbcc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = ticks.tick ? lbcc_pkg::ST_DIV : lbcc_pkg::ST_FIN;
				end
			end
			lbcc_pkg::ST_DIV: begin
				if (cnt_q == 5'(lbcc_pkg::DIV_STEPS - 1)) begin
					state_d = lbcc_pkg::ST_ACC;
				end
			end
			lbcc_pkg::ST_ACC: state_d = lbcc_pkg::ST_LOOP;
			lbcc_pkg::ST_LOOP: begin
				if (!phase_ge) begin
					state_d = lbcc_pkg::ST_FIN;
				end
			end
			lbcc_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = lbcc_pkg::ST_IDLE;
				end
			end
			default: state_d = lbcc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbcc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q      <= 7'd50;
			maxb_q       <= 8'd255;
			count_q      <= 2'd3;
			palette_q[0] <= 24'hFF0000;
			palette_q[1] <= 24'h00FF00;
			palette_q[2] <= 24'h0000FF;
		end else if (cfg.valid) begin
			case (cfg.index)
				lbcc_pkg::REG_SPEED:    speed_q      <= cfg.data[6:0];
				lbcc_pkg::REG_MAXB:     maxb_q       <= cfg.data[7:0];
				lbcc_pkg::REG_COUNT:    count_q      <= cfg.data[1:0];
				lbcc_pkg::REG_PALETTE0: palette_q[0] <= cfg.data;
				lbcc_pkg::REG_PALETTE1: palette_q[1] <= cfg.data;
				lbcc_pkg::REG_PALETTE2: palette_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			tri_q   <= '0;
			level_q <= '0;
			slot_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				lbcc_pkg::ST_IDLE: begin
					if (accept) begin
						done_q <= 1'b0;
					end
				end
				lbcc_pkg::ST_ACC: phase_q <= phase_q + dvd_q[13:0];
				lbcc_pkg::ST_LOOP: begin
					if (phase_ge) begin
						if (tri_n >= twice_max) begin
							// breath over: restart on the next color
							phase_q <= '0;
							tri_q   <= '0;
							level_q <= '0;
							slot_q  <= (slot_n >= count_eff) ? 2'd0 : slot_n;
							done_q  <= 1'b1;
						end else begin
							phase_q <= phase_q - 14'(lbcc_pkg::PHASE_UNIT);
							tri_q   <= tri_n[8:0];
							if (tri_n > {2'd0, maxb_q}) begin
								level_q <= 8'(twice_max - tri_n);
							end else begin
								level_q <= tri_n[7:0];
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// divider datapath; quotient shifts into dvd_q
	always_ff @(posedge clk) begin
		if (accept) begin
			period_q <= period_c;
			rem_q    <= '0;
			dvd_q    <= dividend_c;
			cnt_q    <= '0;
		end else if (state_q == lbcc_pkg::ST_DIV) begin
			rem_q <= trial_ge ? 13'(trial - {1'b0, period_q}) : trial[12:0];
			dvd_q <= {dvd_q[20:0], trial_ge};
			cnt_q <= cnt_q + 5'd1;
		end
	end

	function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] lvl);
		logic [15:0] prod;
		prod = {8'd0, c} * {8'd0, lvl};
		return (lvl == 8'd255) ? c : prod[15:8];
	endfunction

	logic [23:0] col;
	assign col = (slot_q < 2'(lbcc_pkg::PALETTE_SIZE)) ? palette_q[slot_q] : 24'd0;

	logic load_out;
	assign load_out = (state_q == lbcc_pkg::ST_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [7:0] lvl_out_q;
	logic [1:0] idx_out_q;
	logic       done_out_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			red_q      <= scale_channel(col[23:16], level_q);
			green_q    <= scale_channel(col[15:8], level_q);
			blue_q     <= scale_channel(col[7:0], level_q);
			lvl_out_q  <= level_q;
			idx_out_q  <= slot_q;
			done_out_q <= done_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.red_out       = red_q;
	assign result.green_out     = green_q;
	assign result.blue_out      = blue_q;
	assign result.level_now     = lvl_out_q;
	assign result.palette_index = idx_out_q;
	assign result.breath_done   = done_out_q;

	`LBCC_ASSERT_SAME(a_phase_settled, state_q == lbcc_pkg::ST_IDLE,
		phase_q < 14'(lbcc_pkg::PHASE_UNIT), "phase left at or above one unit")
	`LBCC_ASSERT_SAME(a_done_dark, result.valid && result.breath_done,
		result.level_now == 8'd0, "breath end reported with nonzero level")
	`LBCC_ASSERT_SAME(a_slot_range, result.valid,
		result.palette_index < 2'(lbcc_pkg::PALETTE_SIZE), "palette slot out of range")
	`LBCC_ASSERT_NEXT(a_busy_after_accept, accept, !ticks.ready,
		"tick taken again before the request finished")

endmodule

### verif/led_breath_color_cycler_tb.sv
`timescale 1ns / 100ps

module led_breath_color_cycler_tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 600;
	localparam int PHASES         = 10;
	localparam int PHASE_TICKS    = 165;
	localparam int PRESSURE_PHASE = 4;
	localparam int DIRECTED_N     = 30;

	// index that maps to no register; a write must be ignored
	localparam logic [2:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] level;
		logic [1:0] slot;
		logic       done;
	} shade_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        tick;
		logic [2:0]  idx;
		logic [23:0] data;
		logic        check;
		shade_t      want;
	} stim_row_t;

	localparam shade_t BLACK0 = '0;

	logic clk;
	logic arst_n;

	lbcc_tick_if   tick_ch();
	lbcc_result_if res_ch();
	lbcc_cfg_if    cfg_ch();

	led_breath_color_cycler uut (
		.clk    (clk),
		.arst_n (arst_n),
		.ticks  (tick_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// predictor copy of the registers and animation state
	logic [6:0]  cfg_speed  = 7'd50;
	logic [7:0]  cfg_peak   = 8'd255;
	logic [1:0]  cfg_colors = 2'd3;
	logic [23:0] palette [3] = '{24'hFF0000, 24'h00FF00, 24'h0000FF};
	logic [13:0] phase_acc    = '0;
	logic [8:0]  tri_count    = '0;
	logic [7:0]  breath_level = '0;
	logic [1:0]  color_slot   = '0;

	shade_t expected_shades [$];
	int     errors = 0;

	int send_idle   = 0;
	int stall_pct   = 0;
	bit pressure_on = 1'b0;

	stim_row_t directed_rows [DIRECTED_N] = '{
		'{ROW_TICK, 1'b0, lbcc_pkg::REG_SPEED,    24'h000000, 1'b1, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b1, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b0, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, lbcc_pkg::REG_SPEED,    24'hFFFFFF, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, lbcc_pkg::REG_MAXB,     24'hFFFF00, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, lbcc_pkg::REG_COUNT,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b0, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, lbcc_pkg::REG_MAXB,     24'h0000FF, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, lbcc_pkg::REG_PALETTE0, 24'hFFFFFF, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, lbcc_pkg::REG_PALETTE1, 24'h000000, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, lbcc_pkg::REG_PALETTE2, 24'hA5C35A, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, REG_SPARE,              24'h5A5A5A, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, lbcc_pkg::REG_COUNT,    24'h000003, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_CFG,  1'b0, lbcc_pkg::REG_SPEED,    24'h000064, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0},
		'{ROW_TICK, 1'b1, lbcc_pkg::REG_SPEED,    24'h000000, 1'b0, BLACK0}
	};

	function automatic logic [7:0] shade_channel(input logic [7:0] c, input logic [7:0] lvl);
		logic [15:0] prod;
		prod = c * lvl;
		return (lvl == 8'd255) ? c : prod[15:8];
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic store_reg(input logic [2:0] idx, input logic [23:0] data);
		case (idx)
			lbcc_pkg::REG_SPEED:    cfg_speed  = data[6:0];
			lbcc_pkg::REG_MAXB:     cfg_peak   = data[7:0];
			lbcc_pkg::REG_COUNT:    cfg_colors = data[1:0];
			lbcc_pkg::REG_PALETTE0: palette[0] = data;
			lbcc_pkg::REG_PALETTE1: palette[1] = data;
			lbcc_pkg::REG_PALETTE2: palette[2] = data;
			default: ;
		endcase
	endtask

	// one tick of the breath animation; returns the shade shown afterwards
	task automatic advance_breath(input logic t, output shade_t s);
		int unsigned spd, period, step, colors, acc, tc, next_slot;
		logic [23:0] color;
		s.done = 1'b0;
		if (t) begin
			spd    = (cfg_speed > 7'd100) ? 100 : cfg_speed;
			period = 5000 - spd * 4800 / 100;
			step   = (cfg_peak + 1) * 10000 / period;
			colors = (cfg_colors == 2'd0) ? 1 : cfg_colors;
			acc    = phase_acc + step;
			tc     = tri_count;
			while (acc >= 1000) begin
				acc -= 1000;
				tc  += 1;
				if (tc >= 2 * cfg_peak) begin
					// breath over: restart the triangle on the next color
					tc = 0;
					acc = 0;
					breath_level = '0;
					next_slot = color_slot + 1;
					color_slot = (next_slot >= colors) ? 2'd0 : next_slot[1:0];
					s.done = 1'b1;
				end else if (tc > cfg_peak) begin
					breath_level = 8'(2 * cfg_peak - tc);
				end else begin
					breath_level = 8'(tc);
				end
			end
			phase_acc = acc[13:0];
			tri_count = tc[8:0];
		end
		color   = (color_slot < 2'd3) ? palette[color_slot] : '0;
		s.red   = shade_channel(color[23:16], breath_level);
		s.green = shade_channel(color[15:8], breath_level);
		s.blue  = shade_channel(color[7:0], breath_level);
		s.level = breath_level;
		s.slot  = color_slot;
	endtask

	task automatic push_tick(input logic t, input logic typed, input shade_t want);
		shade_t s;
		while ($urandom_range(99) < send_idle) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.tick  <= t;
		do @(posedge clk); while (!tick_ch.ready);
		advance_breath(t, s);
		expected_shades.push_back(typed ? want : s);
	endtask

	// block is idle once every request has produced its result
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (expected_shades.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		store_reg(idx, data);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side: check, then choose ready for the next edge
	initial begin
		shade_t want;
		int hold_left;
		bit pressure_done;
		hold_left = 0;
		pressure_done = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (expected_shades.size() == 0) begin
					$display("%0t: result with none expected, actual %0h %0h %0h %0h %0h %0b",
						$time, res_ch.red_out, res_ch.green_out, res_ch.blue_out,
						res_ch.level_now, res_ch.palette_index, res_ch.breath_done);
					errors++;
				end else begin
					want = expected_shades.pop_front();
					check_field("red_out", want.red, res_ch.red_out);
					check_field("green_out", want.green, res_ch.green_out);
					check_field("blue_out", want.blue, res_ch.blue_out);
					check_field("level_now", want.level, res_ch.level_now);
					check_field("palette_index", 8'(want.slot), 8'(res_ch.palette_index));
					check_field("breath_done", 8'(want.done), 8'(res_ch.breath_done));
				end
			end
			if (pressure_on && !pressure_done) begin
				hold_left = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("led_breath_color_cycler_tb NOT OK");
		$finish;
	end

	initial begin
		logic [23:0] word;
		logic [7:0]  peak_val;
		arst_n        = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.tick  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = lbcc_pkg::REG_SPEED;
		cfg_ch.data   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_N; i++) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				settle();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				push_tick(directed_rows[i].tick, directed_rows[i].check, directed_rows[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			send_idle = 0;
			stall_pct = 0;
			case (ph % 4)
				1: send_idle = 78;
				2: stall_pct = 78;
				3: begin
					send_idle = 17;
					stall_pct = 17;
				end
				default: ;
			endcase

			word = 24'($urandom);
			case ($urandom_range(3))
				0: word[6:0] = 7'd0;
				1: word[6:0] = 7'd100;
				2: word[6:0] = 7'($urandom_range(101, 127));
				default: word[6:0] = 7'($urandom_range(100));
			endcase
			if (ph == 0)
				word[6:0] = 7'd100;
			write_reg(lbcc_pkg::REG_SPEED, word);

			case ($urandom_range(3))
				0: peak_val = 8'd0;
				1: peak_val = 8'd255;
				2: peak_val = 8'($urandom_range(1, 8));
				default: peak_val = 8'($urandom);
			endcase
			if (ph == 0)
				peak_val = 8'($urandom_range(1, 4));
			word = 24'($urandom);
			word[7:0] = peak_val;
			write_reg(lbcc_pkg::REG_MAXB, word);

			write_reg(lbcc_pkg::REG_COUNT, 24'($urandom));
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(3))
					0: word = 24'hFFFFFF;
					1: word = 24'h000000;
					default: word = 24'($urandom);
				endcase
				write_reg(lbcc_pkg::REG_PALETTE0 + 3'(k), word);
			end
			if ($urandom_range(3) == 0)
				write_reg(REG_SPARE, 24'($urandom));

			// long result hold-off while ticks keep coming
			if (ph == PRESSURE_PHASE)
				pressure_on = 1'b1;

			for (int n = 0; n < PHASE_TICKS; n++)
				push_tick($urandom_range(9) != 0, 1'b0, BLACK0);
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("led_breath_color_cycler_tb OK");
		else
			$display("led_breath_color_cycler_tb NOT OK");
		$finish;
	end

endmodule
